### rtl/cached_sorted_key_lookup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cached sorted key lookup
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CACHED_SORTED_KEY_LOOKUP_MACROS_SVH
`define CACHED_SORTED_KEY_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CSK_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csk_pkg.sv
// ----------------------------------------------------------------------------
// csk_pkg
// Types and constants shared by the cached sorted key lookup modules.
// ----------------------------------------------------------------------------
package csk_pkg;

  localparam int KEY_W        = 32;
  localparam int ID_W         = 16;
  localparam int COUNT_W      = 13;
  localparam int LOAD_INDEX_W = 12;
  localparam int SLICE_W      = 6;

  localparam logic [KEY_W-1:0] KEY_VARIANT_BIT = 32'h8000_0000;
  localparam logic [KEY_W-1:0] SLICE_KEY_TAG   = 32'h4000_0000;
  localparam logic [KEY_W-1:0] CACHE_KEY_RESET = 32'hffff_ffff;
  localparam logic [7:0]       SCENE_NONE      = 8'hff;

  // Input item kind carried on the slave tuser
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } csk_func_e;

  // Register select, taken from paddr[2]
  typedef enum logic {
    REG_ENTRY_COUNT    = 1'b0,
    REG_VARIANT_SELECT = 1'b1
  } csk_reg_e;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_HIT,
    ST_SRCH,
    ST_INS,
    ST_POST,
    ST_RESP
  } csk_state_e;

  // Binary search unit phase
  typedef enum logic {
    PH_ISSUE,
    PH_CHECK
  } csk_phase_e;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } csk_outcome_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } csk_cache_ctrl_t;

  typedef struct packed {
    logic         hit;
    csk_outcome_t outcome;
  } csk_cache_stat_t;

  typedef struct packed {
    logic start;
    logic load_we;
  } csk_srch_ctrl_t;

  typedef struct packed {
    logic         done;
    csk_outcome_t outcome;
  } csk_srch_stat_t;

endpackage

### rtl/csk_ram.sv
// ----------------------------------------------------------------------------
// csk_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/csk_cache.sv
// ----------------------------------------------------------------------------
// csk_cache
// Fully associative key cache with first-in, first-out replacement.
// ----------------------------------------------------------------------------
module csk_cache #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  csk_pkg::csk_cache_ctrl_t     ctrl_i,
  input  logic [csk_pkg::KEY_W-1:0]    key_i,
  input  csk_pkg::csk_outcome_t        ins_outcome_i,
  output csk_pkg::csk_cache_stat_t     stat_o
);

  import csk_pkg::*;

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [KEY_W-1:0]         keys_q [CACHE_ENTRIES];
  csk_outcome_t             ids_q  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] match_q;
  logic [CW-1:0]            ptr_q;
  logic [CW-1:0]            ptr_d;
  logic [ID_W:0]            sel;

  // Advance the replacement pointer with wrap
  always_comb begin
    if (ptr_q == CW'(CACHE_ENTRIES - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  // Compare all entries, insert at the pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        keys_q[i] <= CACHE_KEY_RESET;
        ids_q[i]  <= '0;
      end
      match_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (ctrl_i.cmp_en) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          match_q[i] <= (keys_q[i] == key_i);
        end
      end
      if (ctrl_i.ins_en) begin
        keys_q[ptr_q] <= key_i;
        ids_q[ptr_q]  <= ins_outcome_i;
        ptr_q         <= ptr_d;
      end
    end
  end

  // Select the hit entry; duplicate keys only occur among reset entries,
  // which all hold the same outcome, so an OR of the matches is exact
  always_comb begin
    sel = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (match_q[i]) begin
        sel = sel | ids_q[i];
      end
    end
  end

  assign stat_o.hit     = |match_q;
  assign stat_o.outcome = csk_outcome_t'(sel);

endmodule

### rtl/csk_search.sv
// ----------------------------------------------------------------------------
// csk_search
// Sorted key table and binary search unit with one shared key comparator.
// ----------------------------------------------------------------------------
module csk_search #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csk_pkg::csk_srch_ctrl_t          ctrl_i,
  input  logic [csk_pkg::KEY_W-1:0]        key_i,
  input  logic [csk_pkg::COUNT_W-1:0]      entry_count_i,
  input  logic [csk_pkg::LOAD_INDEX_W-1:0] load_index_i,
  input  logic [csk_pkg::KEY_W-1:0]        load_key_i,
  input  logic [csk_pkg::ID_W-1:0]         load_id_i,
  output csk_pkg::csk_srch_stat_t          stat_o
);

  import csk_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = ID_W + KEY_W;

  logic           busy_q;
  csk_phase_e     phase_q;
  logic [AW:0]    lo_q;
  logic [AW:0]    hi_q;
  logic [AW+1:0]  sum;
  logic [AW-1:0]  mid;
  logic [AW:0]    hi_init;
  logic [31:0]    cnt32;
  logic [31:0]    idx32;
  logic           wr_en;
  logic           rd_en;
  logic           in_range;
  logic [EW-1:0]  rdata;
  logic [KEY_W-1:0] rd_key;
  logic [ID_W-1:0]  rd_id;
  logic           key_eq;
  logic           key_gt;
  logic           done_q;
  csk_outcome_t   outcome_q;

  // Load port: drop writes beyond the table depth
  assign idx32 = 32'(load_index_i);
  assign wr_en = ctrl_i.load_we && (idx32 < 32'(TABLE_DEPTH));

  // Clamp the entry count to the table depth
  assign cnt32   = 32'(entry_count_i);
  assign hi_init = (cnt32 > 32'(TABLE_DEPTH)) ? (AW+1)'(TABLE_DEPTH) : (AW+1)'(cnt32);

  // Midpoint of the current interval
  assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = sum[AW:1];
  assign in_range = lo_q < hi_q;
  assign rd_en    = busy_q && (phase_q == PH_ISSUE) && in_range;

  csk_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx32[AW-1:0]),
    .wdata_i ({load_id_i, load_key_i}),
    .re_i    (rd_en),
    .raddr_i (mid),
    .rdata_o (rdata)
  );

  // Shared comparator
  assign rd_key = rdata[KEY_W-1:0];
  assign rd_id  = rdata[EW-1:KEY_W];
  assign key_eq = (key_i == rd_key);
  assign key_gt = (key_i > rd_key);

  // Probe sequencer: issue a read, then narrow the interval
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= PH_ISSUE;
      lo_q      <= '0;
      hi_q      <= '0;
      done_q    <= 1'b0;
      outcome_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= PH_ISSUE;
        lo_q    <= '0;
        hi_q    <= hi_init;
      end else if (busy_q) begin
        case (phase_q)
          PH_ISSUE: begin
            if (in_range) begin
              phase_q <= PH_CHECK;
            end else begin
              busy_q    <= 1'b0;
              done_q    <= 1'b1;
              outcome_q <= '0;
            end
          end
          PH_CHECK: begin
            phase_q <= PH_ISSUE;
            if (key_eq) begin
              busy_q            <= 1'b0;
              done_q            <= 1'b1;
              outcome_q.found   <= 1'b1;
              outcome_q.id      <= rd_id;
            end else if (key_gt) begin
              lo_q <= {1'b0, mid} + (AW+1)'(1);
            end else begin
              hi_q <= {1'b0, mid};
            end
          end
          default: begin
            phase_q <= PH_ISSUE;
          end
        endcase
      end
    end
  end

  assign stat_o.done    = done_q;
  assign stat_o.outcome = outcome_q;

endmodule

### rtl/cached_sorted_key_lookup.sv
// ----------------------------------------------------------------------------
// cached_sorted_key_lookup
// Maps a location to a flag id through a FIFO key cache and a sorted table.
//
//   channel  | dir | handshake                | payload
//   ---------+-----+--------------------------+------------------------------
//   s_axis   | in  | s_axis_tvalid/tready     | tdata: load/location fields
//   m_axis   | out | m_axis_tvalid/tready     | tdata: flag_id, tuser: found
//   apb      | in  | psel/penable/pwrite      | entry_count, variant_select
//
// A lookup checks the cache for each key; a miss adds a table search of
// P <= clog2(entry_count+1) probes, and the table memory is read once per
// probe. Up to two keys per lookup. Reset loads the cache with all-ones keys
// in flip-flops; the table is not cleared. One finished result waits in the
// output register while the next item is taken; a lookup stalls only if
// that register is still full.
// ----------------------------------------------------------------------------
`include "cached_sorted_key_lookup_macros.svh"

module cached_sorted_key_lookup #(
  parameter int CACHE_ENTRIES = 32,
  parameter int TABLE_DEPTH   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // load_index, load_key, load_id, scene, setup, room, actor_index, slice
  input  logic [95:0] s_axis_tdata,
  // func
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // flag_id
  output logic [15:0] m_axis_tdata,
  // found
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import csk_pkg::*;

  csk_state_e      state_q;
  csk_state_e      state_d;
  logic [KEY_W-1:0]   key_q;
  logic [SLICE_W-1:0] slice_q;
  logic               second_q;
  csk_outcome_t       outcome_q;
  logic [COUNT_W-1:0] entry_count_q;
  logic               variant_q;
  logic               out_valid_q;
  logic [ID_W-1:0]    out_id_q;
  logic               out_found_q;

  csk_cache_ctrl_t cache_ctrl;
  csk_cache_stat_t cache_stat;
  csk_srch_ctrl_t  srch_ctrl;
  csk_srch_stat_t  srch_stat;

  logic                    in_xfer;
  logic                    out_free;
  logic                    cfg_wr;
  csk_func_e               in_func;
  logic [LOAD_INDEX_W-1:0] in_load_index;
  logic [KEY_W-1:0]        in_load_key;
  logic [ID_W-1:0]         in_load_id;
  logic [7:0]              in_scene;
  logic [1:0]              in_setup;
  logic [5:0]              in_room;
  logic [7:0]              in_actor;
  logic [SLICE_W-1:0]      in_slice;
  logic [KEY_W-1:0]        loc_key;
  logic [KEY_W-1:0]        slice_key;
  logic                    want_second;

  // Unpack the input transfer
  assign in_func       = csk_func_e'(s_axis_tuser);
  assign in_load_index = s_axis_tdata[11:0];
  assign in_load_key   = s_axis_tdata[43:12];
  assign in_load_id    = s_axis_tdata[59:44];
  assign in_scene      = s_axis_tdata[67:60];
  assign in_setup      = s_axis_tdata[69:68];
  assign in_room       = s_axis_tdata[75:70];
  assign in_actor      = s_axis_tdata[83:76];
  assign in_slice      = s_axis_tdata[89:84];

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Key formation
  assign loc_key = 32'(in_actor) | (32'(in_room) << 8) | (32'(in_setup) << 16)
                 | (32'(in_scene) << 18) | (variant_q ? KEY_VARIANT_BIT : '0);
  assign slice_key   = SLICE_KEY_TAG | (32'(slice_q) << 16) | 32'(outcome_q.id);
  assign want_second = outcome_q.found && (slice_q != '0) && !second_q;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      variant_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (csk_reg_e'(paddr[2]))
        REG_ENTRY_COUNT:    entry_count_q <= pwdata[COUNT_W-1:0];
        REG_VARIANT_SELECT: variant_q     <= pwdata[0];
        default:            entry_count_q <= entry_count_q;
      endcase
    end
  end

  always_comb begin
    case (csk_reg_e'(paddr[2]))
      REG_ENTRY_COUNT:    prdata = 32'(entry_count_q);
      REG_VARIANT_SELECT: prdata = 32'(variant_q);
      default:            prdata = '0;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and unit controls
  always_comb begin
    state_d       = state_q;
    cache_ctrl    = '0;
    srch_ctrl     = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          if (in_func == FUNC_LOAD) begin
            srch_ctrl.load_we = 1'b1;
          end else if (in_scene == SCENE_NONE) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        cache_ctrl.cmp_en = 1'b1;
        state_d           = ST_HIT;
      end
      ST_HIT: begin
        if (cache_stat.hit) begin
          state_d = ST_POST;
        end else begin
          srch_ctrl.start = 1'b1;
          state_d         = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch_stat.done) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        cache_ctrl.ins_en = 1'b1;
        state_d           = ST_POST;
      end
      ST_POST: begin
        state_d = want_second ? ST_CMP : ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Lookup datapath: current key, slice and outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && in_xfer && in_func == FUNC_LOOKUP) begin
        second_q <= 1'b0;
      end else if (state_q == ST_POST && want_second) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_xfer && in_func == FUNC_LOOKUP) begin
      key_q     <= loc_key;
      slice_q   <= in_slice;
      outcome_q <= '0;
    end else if (state_q == ST_HIT && cache_stat.hit) begin
      outcome_q <= cache_stat.outcome;
    end else if (state_q == ST_SRCH && srch_stat.done) begin
      outcome_q <= srch_stat.outcome;
    end else if (state_q == ST_POST && want_second) begin
      key_q <= slice_key;
    end
  end

  // Output register: hold until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_found_q <= outcome_q.found;
      out_id_q    <= outcome_q.found ? outcome_q.id : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_found_q;

  csk_cache #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (cache_ctrl),
    .key_i         (key_q),
    .ins_outcome_i (outcome_q),
    .stat_o        (cache_stat)
  );

  csk_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (srch_ctrl),
    .key_i         (key_q),
    .entry_count_i (entry_count_q),
    .load_index_i  (in_load_index),
    .load_key_i    (in_load_key),
    .load_id_i     (in_load_id),
    .stat_o        (srch_stat)
  );

  // Checks
  `CSK_ASSERT_SAME(a_done_in_srch, clk_i, rst_ni, srch_stat.done, state_q == ST_SRCH, "search done outside search state")
  `CSK_ASSERT_SAME(a_ins_after_done, clk_i, rst_ni, cache_ctrl.ins_en, $past(srch_stat.done), "cache insert without finished search")
  `CSK_ASSERT_SAME(a_notfound_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "not-found result with nonzero id")
  `CSK_ASSERT_NEXT(a_second_slice, clk_i, rst_ni, state_q == ST_POST && want_second, second_q && slice_q != '0, "second key without slice")

endmodule

### tb/sv/tb_cached_sorted_key_lookup.sv
// ----------------------------------------------------------------------------
// tb_cached_sorted_key_lookup
// Self-checking bench for the cached sorted key lookup. Loads sorted key
// tables over the input stream, programs the table size and variant through
// the register port, and checks every flag id returned on the output stream
// against a predictor that tracks the FIFO cache and the binary search.
// ----------------------------------------------------------------------------
module tb_cached_sorted_key_lookup;
  import csk_pkg::*;

  localparam int CACHE_ENTRIES  = 32;
  localparam int TABLE_DEPTH    = 4096;
  localparam int POOL_SIZE      = 12;
  localparam int ID_POOL_SIZE   = 8;
  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 130;
  localparam int MID_TABLE_ROWS = 150;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 5000;

  typedef struct {
    csk_func_e         func;
    logic [11:0]       load_index;
    logic [KEY_W-1:0]  load_key;
    logic [ID_W-1:0]   load_id;
    logic [7:0]        scene;
    logic [1:0]        setup;
    logic [5:0]        room;
    logic [7:0]        actor_index;
    logic [5:0]        slice;
  } lookup_item_t;

  // Tracks cache, table and registers; holds the flag ids still owed
  class flag_lookup_board;
    logic [KEY_W-1:0] cache_key [CACHE_ENTRIES];
    csk_outcome_t     cache_out [CACHE_ENTRIES];
    int unsigned      fifo_ptr;
    logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
    logic [ID_W-1:0]  tbl_id [TABLE_DEPTH];
    int unsigned      entry_count;
    bit               variant;
    csk_outcome_t     pending_flags [$];
    int               errors;

    function new();
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        cache_key[i] = CACHE_KEY_RESET;
        cache_out[i] = '0;
      end
      fifo_ptr    = 0;
      entry_count = 0;
      variant     = 1'b0;
      errors      = 0;
    endfunction

    function logic [KEY_W-1:0] loc_key(logic [7:0] scene, logic [1:0] setup,
                                       logic [5:0] room, logic [7:0] actor, bit v);
      logic [KEY_W-1:0] key;
      key = {6'b0, scene, setup, 2'b00, room, actor};
      if (v) key = key | KEY_VARIANT_BIT;
      return key;
    endfunction

    function logic [KEY_W-1:0] slice_key(logic [5:0] slice, logic [ID_W-1:0] id);
      return SLICE_KEY_TAG | {10'b0, slice, id};
    endfunction

    // Cache compare, then binary search on a miss; a miss inserts the outcome
    function csk_outcome_t probe_key(logic [KEY_W-1:0] key);
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      csk_outcome_t res;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (cache_key[i] == key) return cache_out[i];
      end
      lo  = 0;
      hi  = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
      res = '0;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (tbl_key[mid] == key) begin
          res.found = 1'b1;
          res.id    = tbl_id[mid];
          break;
        end
        if (key > tbl_key[mid]) lo = mid + 1;
        else hi = mid;
      end
      cache_key[fifo_ptr] = key;
      cache_out[fifo_ptr] = res;
      fifo_ptr = (fifo_ptr + 1) % CACHE_ENTRIES;
      return res;
    endfunction

    function void set_config(csk_reg_e sel, logic [31:0] value);
      if (sel == REG_ENTRY_COUNT) entry_count = 32'(value[COUNT_W-1:0]);
      else variant = value[0];
    endfunction

    function void note_item(lookup_item_t it);
      csk_outcome_t res;
      if (it.func == FUNC_LOAD) begin
        tbl_key[it.load_index] = it.load_key;
        tbl_id[it.load_index]  = it.load_id;
        return;
      end
      res = '0;
      if (it.scene != SCENE_NONE) begin
        res = probe_key(loc_key(it.scene, it.setup, it.room, it.actor_index, variant));
        if (res.found && it.slice != 0) res = probe_key(slice_key(it.slice, res.id));
      end
      if (!res.found) res = '0;
      pending_flags.push_back(res);
    endfunction

    function void check_result(logic [ID_W-1:0] flag_id, logic found);
      csk_outcome_t want;
      if (pending_flags.size() == 0) begin
        $error("result with no pending lookup: flag_id %h found %b", flag_id, found);
        errors++;
        return;
      end
      want = pending_flags.pop_front();
      if (flag_id !== want.id) begin
        $error("flag_id: expected %h, actual %h", want.id, flag_id);
        errors++;
      end
      if (found !== want.found) begin
        $error("found: expected %b, actual %b", want.found, found);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  flag_lookup_board sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int quiet;

  logic [7:0]      pool_scene [POOL_SIZE];
  logic [1:0]      pool_setup [POOL_SIZE];
  logic [5:0]      pool_room [POOL_SIZE];
  logic [7:0]      pool_actor [POOL_SIZE];
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

  cached_sorted_key_lookup #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .TABLE_DEPTH  (TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // tdata from bit 0: load_index, load_key, load_id, scene, setup, room,
  // actor_index, slice, then zero fill
  function automatic logic [95:0] pack_item(lookup_item_t it);
    return {6'b0, it.slice, it.actor_index, it.room, it.setup, it.scene,
            it.load_id, it.load_key, it.load_index};
  endfunction

  function automatic lookup_item_t random_fields();
    lookup_item_t it;
    it.func        = csk_func_e'($urandom_range(1));
    it.load_index  = 12'($urandom_range(TABLE_DEPTH - 1));
    it.load_key    = $urandom;
    it.load_id     = 16'($urandom);
    it.scene       = 8'($urandom);
    it.setup       = 2'($urandom);
    it.room        = 6'($urandom);
    it.actor_index = 8'($urandom);
    it.slice       = 6'($urandom);
    return it;
  endfunction

  function automatic lookup_item_t lookup_of(logic [7:0] scene, logic [1:0] setup,
                                            logic [5:0] room, logic [7:0] actor,
                                            logic [5:0] slice);
    lookup_item_t it;
    it             = random_fields();
    it.func        = FUNC_LOOKUP;
    it.scene       = scene;
    it.setup       = setup;
    it.room        = room;
    it.actor_index = actor;
    it.slice       = slice;
    return it;
  endfunction

  function automatic logic [5:0] random_slice();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 6'd0;
    if (pick < 80) return 6'($urandom_range(3, 1));
    return 6'($urandom_range(63));
  endfunction

  // Mostly pool locations so lookups hit; some no-flag scenes and noise
  function automatic lookup_item_t random_lookup();
    lookup_item_t it;
    int           pick;
    int           k;
    it      = random_fields();
    it.func = FUNC_LOOKUP;
    pick    = $urandom_range(99);
    if (pick < 70) begin
      k              = $urandom_range(POOL_SIZE - 1);
      it.scene       = pool_scene[k];
      it.setup       = pool_setup[k];
      it.room        = pool_room[k];
      it.actor_index = pool_actor[k];
      it.slice       = random_slice();
    end else if (pick < 80) begin
      it.scene = SCENE_NONE;
    end
    return it;
  endfunction

  task automatic new_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_scene[k] = 8'($urandom_range(254));
      pool_setup[k] = 2'($urandom);
      pool_room[k]  = 6'($urandom);
      pool_actor[k] = 8'($urandom);
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);
  endtask

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(lookup_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  // Sort {key, id} pairs and load them from table position 0 upward
  task automatic load_entries(logic [47:0] ents [$]);
    lookup_item_t it;
    ents.sort();
    foreach (ents[i]) begin
      it            = random_fields();
      it.func       = FUNC_LOAD;
      it.load_index = 12'(i);
      it.load_key   = ents[i][47:16];
      it.load_id    = ents[i][15:0];
      send_item(it);
    end
  endtask

  task automatic load_table(int n, bit v);
    logic [47:0]      ents [$];
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    int               pick;
    int               k;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      k    = $urandom_range(POOL_SIZE - 1);
      if (pick < 40) begin
        key = sb.loc_key(pool_scene[k], pool_setup[k], pool_room[k], pool_actor[k],
                         ($urandom_range(99) < 85) ? v : !v);
      end else if (pick < 70) begin
        key = sb.slice_key(($urandom_range(99) < 80) ? 6'($urandom_range(3, 1))
                                                     : 6'($urandom_range(63, 1)),
                           id_pool[$urandom_range(ID_POOL_SIZE - 1)]);
      end else begin
        key = $urandom;
      end
      id = ($urandom_range(1) == 0) ? id_pool[$urandom_range(ID_POOL_SIZE - 1)]
                                    : ID_W'($urandom);
      ents.push_back({key, id});
    end
    load_entries(ents);
  endtask

  task automatic apb_access(input logic wr, input csk_reg_e sel,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register, then read it back
  task automatic set_reg(csk_reg_e sel, logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, sel, value, rd);
    sb.set_config(sel, value);
    apb_access(1'b0, sel, '0, rd);
    if (sel == REG_ENTRY_COUNT) begin
      if (rd[COUNT_W-1:0] !== value[COUNT_W-1:0]) begin
        $error("entry_count: expected %h, actual %h", value[COUNT_W-1:0], rd[COUNT_W-1:0]);
        sb.errors++;
      end
    end else if (rd[0] !== value[0]) begin
      $error("variant_select: expected %b, actual %b", value[0], rd[0]);
      sb.errors++;
    end
  endtask

  // Hold the input until every result is back and loads have drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_flags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Output side: check each transfer, stall at random or for a long hold
  initial begin
    m_axis_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("tb_cached_sorted_key_lookup failed");
    $finish;
  end

  initial begin
    logic [47:0] ents [$];
    int spine_pos [$];
    lookup_item_t it;
    int n;
    int cnt;
    int mode;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_LOAD;
    s_axis_tvalid <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: no-flag scene with all fields high, then misses at the extremes
    send_item(lookup_of(SCENE_NONE, 2'd3, 6'd63, 8'hff, 6'd63));
    send_item(lookup_of(8'd0, 2'd0, 6'd0, 8'd0, 6'd0));
    send_item(lookup_of(8'd254, 2'd3, 6'd63, 8'hff, 6'd63));

    // Small known table; two of its keys are already cached as misses
    ents.push_back({sb.loc_key(8'd0, 2'd0, 6'd0, 8'd0, 1'b0), 16'h0005});
    ents.push_back({sb.loc_key(8'd1, 2'd2, 6'd5, 8'd7, 1'b0), 16'h1234});
    ents.push_back({sb.loc_key(8'd2, 2'd0, 6'd0, 8'd0, 1'b0), 16'h0001});
    ents.push_back({sb.loc_key(8'd254, 2'd3, 6'd63, 8'hff, 1'b0), 16'hffff});
    ents.push_back({sb.slice_key(6'd1, 16'h1234), 16'h0000});
    ents.push_back({sb.slice_key(6'd63, 16'hffff), 16'habcd});
    load_entries(ents);
    it            = random_fields();
    it.func       = FUNC_LOAD;
    it.load_index = 12'(TABLE_DEPTH - 1);
    it.load_key   = '1;
    it.load_id    = '1;
    send_item(it);
    settle();
    set_reg(REG_ENTRY_COUNT, 32'd6);

    // Table hit, slice hit with id zero, slice miss, stale misses, table hit, repeat hit
    send_item(lookup_of(8'd1, 2'd2, 6'd5, 8'd7, 6'd0));
    send_item(lookup_of(8'd1, 2'd2, 6'd5, 8'd7, 6'd1));
    send_item(lookup_of(8'd1, 2'd2, 6'd5, 8'd7, 6'd2));
    send_item(lookup_of(8'd254, 2'd3, 6'd63, 8'hff, 6'd63));
    send_item(lookup_of(8'd0, 2'd0, 6'd0, 8'd0, 6'd0));
    send_item(lookup_of(8'd2, 2'd0, 6'd0, 8'd0, 6'd0));
    send_item(lookup_of(8'd1, 2'd2, 6'd5, 8'd7, 6'd0));
    settle();
    set_reg(REG_VARIANT_SELECT, 32'd1);
    send_item(lookup_of(8'd1, 2'd2, 6'd5, 8'd7, 6'd0));

    // Count above the depth: load only the positions a search visits when
    // the key equals one of them or lies outside the loaded key range
    spine_pos.push_back(0);
    for (int b = 0; b < $clog2(TABLE_DEPTH); b++) spine_pos.push_back(1 << b);
    for (int b = $clog2(TABLE_DEPTH) - 2; b >= 0; b--) begin
      spine_pos.push_back(TABLE_DEPTH - (1 << b));
    end
    spine_pos.sort();
    foreach (spine_pos[j]) begin
      it            = random_fields();
      it.func       = FUNC_LOAD;
      it.load_index = 12'(spine_pos[j]);
      it.load_key   = sb.loc_key(8'(20 + 8 * j), 2'd1, 6'd3, 8'(j), 1'b1);
      send_item(it);
    end
    settle();
    set_reg(REG_ENTRY_COUNT, 32'd8191);
    foreach (spine_pos[j]) begin
      send_item(lookup_of(8'(20 + 8 * j), 2'd1, 6'd3, 8'(j), 6'd0));
    end
    send_item(lookup_of(8'd0, 2'd1, 6'd3, 8'd0, 6'd0));
    send_item(lookup_of(8'd250, 2'd1, 6'd3, 8'd0, 6'd0));

    // Random phases over table sizes, variants and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      mode = p % 4;
      settle();
      send_idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 32 : 0;
      recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 32 : 0;
      new_pool();
      set_reg(REG_VARIANT_SELECT, p % 2);
      case (p)
        0: begin
          n   = 1;
          cnt = 1;
        end
        1: begin
          n   = MID_TABLE_ROWS;
          cnt = MID_TABLE_ROWS;
        end
        2: begin
          n   = 0;
          cnt = MID_TABLE_ROWS;
        end
        3: begin
          n   = $urandom_range(48, 2);
          cnt = 0;
        end
        default: begin
          n   = $urandom_range(48, 2);
          cnt = ($urandom_range(3) == 0) ? $urandom_range(n, 1) : n;
        end
      endcase
      if (n > 0) load_table(n, 1'(p % 2));
      settle();
      set_reg(REG_ENTRY_COUNT, cnt);
      if (p == 4) hold_req = 1'b1;
      if (n == 0) n = TABLE_DEPTH;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 6) begin
          it      = random_fields();
          it.func = FUNC_LOAD;
          if ($urandom_range(1) == 0) it.load_index = 12'($urandom_range(n - 1));
        end else begin
          it = random_lookup();
        end
        send_item(it);
      end
    end

    settle();
    if (sb.errors == 0) $display("tb_cached_sorted_key_lookup passed");
    else $display("tb_cached_sorted_key_lookup failed");
    $finish;
  end

endmodule
